// ----- hdl/go_back_n_sender_macros.svh -----
// ----------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Immediate-implication and next-cycle-implication checks on i_clk.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_MACROS_SVH
`define GO_BACK_N_SENDER_MACROS_SVH
`ifndef SYNTH
`define GBN_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("go_back_n_sender: assertion failed");
`define GBN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("go_back_n_sender: assertion failed");
`else
`define GBN_ASSERT_IMPL(label, ante, cons)
`define GBN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// Widths, codes and types shared by the Go-Back-N sender and its interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

    localparam int DEF_FRAME_SLOTS   = 128;
    localparam int DEF_PAYLOAD_BYTES = 8;
    localparam int DEF_SEQ_SPACE     = 8;

    localparam int ACT_W   = 2;
    localparam int CHUNK_W = 64;
    localparam int NUM_W   = 3;
    localparam int KIND_W  = 2;
    localparam int WIN_W   = 3;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 3'd4;

    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SENT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [NUM_W-1:0]   num;
        logic [CHUNK_W-1:0] payload;
        logic               last;
    } t_evt;

endpackage

`default_nettype wire

// ----- hdl/gbn_req_if.sv -----
// ----------------------------------------------------------------------------
// gbn_req_if
// Request channel: load, acknowledgement and timeout transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbn_req_if import gbn_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [CHUNK_W-1:0] chunk_payload;
    logic               last_chunk;
    logic [NUM_W-1:0]   ack_number;

    modport source (
        output valid, action, chunk_payload, last_chunk, ack_number,
        input  ready
    );

    modport sink (
        input  valid, action, chunk_payload, last_chunk, ack_number,
        output ready
    );

endinterface

`default_nettype wire

// ----- hdl/gbn_evt_if.sv -----
// ----------------------------------------------------------------------------
// gbn_evt_if
// Event channel: sent, resent, complete and rejected transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbn_evt_if import gbn_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  event_kind;
    logic [NUM_W-1:0]   frame_number;
    logic [CHUNK_W-1:0] frame_payload;
    logic               run_end;

    modport source (
        output valid, event_kind, frame_number, frame_payload, run_end,
        input  ready
    );

    modport sink (
        input  valid, event_kind, frame_number, frame_payload, run_end,
        output ready
    );

endinterface

`default_nettype wire

// ----- hdl/go_back_n_sender.sv -----
// ----------------------------------------------------------------------------
// go_back_n_sender
// Go-Back-N sender: stores message chunks in a payload memory, sends frames
// within the window, slides on cumulative acknowledgements, resends on timeout.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       content
//  i_req     in    valid/ready     action, chunk, last flag, ack number
//  o_evt     out   valid/ready     event kind, frame number, payload, run end
//  i_cfg_*   in    write enable    window size
//
//  A load that is not final is accepted in S_IDLE. A final load or a matching
//  acknowledgement passes through the planning state S_PLAN, then sends one frame
//  per cycle while the result queue has room; a timeout resends one frame per cycle
//  while the queue has room, bounded by the single read port of the payload memory.
//  Reset is synchronous; the payload memory is not cleared.
//  A two-entry result queue lets frames stream while the sink stalls briefly.
// ----------------------------------------------------------------------------
`default_nettype none

`include "go_back_n_sender_macros.svh"

module go_back_n_sender import gbn_pkg::*; #(
    parameter int FRAME_SLOTS   = DEF_FRAME_SLOTS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
    parameter int SEQ_SPACE     = DEF_SEQ_SPACE
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [WIN_W-1:0] i_cfg_wdata,
    gbn_req_if.sink               i_req,
    gbn_evt_if.source             o_evt
);

    localparam int IDX_W  = $clog2(FRAME_SLOTS);
    localparam int CNT_W  = $clog2(FRAME_SLOTS + 1);
    localparam int SEQ_W  = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
    localparam int DATA_W = 8 * PAYLOAD_BYTES;
    localparam int AW     = ((SEQ_W > NUM_W) ? SEQ_W : NUM_W) + 1;
    localparam int CW     = ((AW > CNT_W) ? AW : CNT_W) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PLAN  = 2'd1;
    localparam logic [1:0] S_BURST = 2'd2;

    logic [1:0]        r_state;
    logic              r_sending;
    logic [CNT_W-1:0]  r_loaded;
    logic [CNT_W-1:0]  r_base;
    logic [CNT_W-1:0]  r_next;
    logic [SEQ_W-1:0]  r_seq_ctr;
    logic [SEQ_W-1:0]  r_base_seq;
    logic [SEQ_W-1:0]  r_next_seq;
    logic [WIN_W-1:0]  r_window;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_rd_end;
    logic [SEQ_W-1:0]  r_rd_seq;
    logic [KIND_W-1:0] r_rd_kind;
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_payload_mem [FRAME_SLOTS];

    logic              r_pend_vld;
    logic [KIND_W-1:0] r_pend_kind;
    logic [NUM_W-1:0]  r_pend_num;
    logic              r_pend_last;
    logic              r_out_vld;
    logic              r_skid_vld;
    t_evt              r_out;
    t_evt              r_skid;

    logic              pop;
    logic [1:0]        occ_left;
    logic              can_push;
    logic              accept;
    logic              is_load;
    logic              load_rej;
    logic              load_wr;
    logic              plan_done;
    logic              issue;
    logic              rd_last;
    logic [SEQ_W-1:0]  rd_seq_inc;
    logic [SEQ_W-1:0]  ctr_inc;
    logic [AW-1:0]     ack_w;
    logic [AW-1:0]     bseq_w;
    logic [AW-1:0]     seq_w;
    logic [AW-1:0]     ack_off;
    logic              ack_hit;
    logic [SEQ_W-1:0]  ack_seq_nx;
    logic [WIN_W-1:0]  win_nz;
    logic [CW-1:0]     win_eff;
    logic [CW-1:0]     lim;
    logic [CNT_W-1:0]  snd_end;
    logic              all_acked;
    t_evt              pend_evt;

    // queue occupancy and handshake
    always_comb begin
        pop      = r_out_vld & o_evt.ready;
        occ_left = 2'(r_out_vld) + 2'(r_skid_vld) + 2'(r_pend_vld) - 2'(pop);
        can_push = occ_left < 2'd2;
    end

    assign i_req.ready = (r_state == S_IDLE) && can_push;
    assign accept      = i_req.valid && i_req.ready;
    assign is_load     = accept && (i_req.action == ACT_LOAD);
    assign load_rej    = is_load && (r_sending || (r_loaded == CNT_W'(FRAME_SLOTS)));
    assign load_wr     = is_load && !load_rej;

    // acknowledgement match against the outstanding frames
    always_comb begin
        ack_w   = AW'(i_req.ack_number);
        bseq_w  = AW'(r_base_seq);
        seq_w   = AW'(SEQ_SPACE);
        ack_off = (ack_w >= bseq_w) ? (ack_w - bseq_w) : (ack_w + seq_w - bseq_w);
        ack_hit = (ack_w < seq_w) && (CW'(ack_off) < CW'(r_next - r_base));
        ack_seq_nx = (ack_w == seq_w - AW'(1)) ? '0 : SEQ_W'(ack_w + AW'(1));
    end

    // window planning
    always_comb begin
        win_nz    = (r_window == '0) ? WIN_W'(1) : r_window;
        win_eff   = (AW'(win_nz) >= AW'(SEQ_SPACE)) ? CW'(SEQ_SPACE - 1) : CW'(win_nz);
        lim       = CW'(r_base) + win_eff;
        snd_end   = (lim < CW'(r_loaded)) ? CNT_W'(lim) : r_loaded;
        all_acked = r_base >= r_loaded;
        plan_done = (r_state == S_PLAN) && all_acked && can_push;
        issue     = (r_state == S_BURST) && can_push;
        rd_last   = (r_rd_idx + CNT_W'(1)) == r_rd_end;
        rd_seq_inc = (r_rd_seq == SEQ_W'(SEQ_SPACE - 1)) ? '0 : r_rd_seq + SEQ_W'(1);
        ctr_inc    = (r_seq_ctr == SEQ_W'(SEQ_SPACE - 1)) ? '0 : r_seq_ctr + SEQ_W'(1);
    end

    always_comb begin
        pend_evt.kind    = r_pend_kind;
        pend_evt.num     = r_pend_num;
        pend_evt.last    = r_pend_last;
        pend_evt.payload = ((r_pend_kind == KIND_SENT) || (r_pend_kind == KIND_RESENT)) ?
                           CHUNK_W'(r_rd_data) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sending  <= 1'b0;
            r_loaded   <= '0;
            r_base     <= '0;
            r_next     <= '0;
            r_seq_ctr  <= '0;
            r_base_seq <= '0;
            r_next_seq <= '0;
            r_window   <= WINDOW_RESET;
            r_rd_idx   <= '0;
            r_rd_end   <= '0;
            r_rd_seq   <= '0;
            r_rd_kind  <= KIND_SENT;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            r_pend_vld <= load_rej || plan_done || issue;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_req.action)
                            ACT_LOAD: begin
                                if (load_wr) begin
                                    if (r_loaded == '0) begin
                                        r_base_seq <= r_seq_ctr;
                                        r_next_seq <= r_seq_ctr;
                                    end
                                    r_loaded  <= r_loaded + CNT_W'(1);
                                    r_seq_ctr <= ctr_inc;
                                    if (i_req.last_chunk) begin
                                        r_sending <= 1'b1;
                                        r_base    <= '0;
                                        r_next    <= '0;
                                        r_state   <= S_PLAN;
                                    end
                                end
                            end
                            ACT_ACK: begin
                                if (r_sending && ack_hit) begin
                                    r_base     <= r_base + CNT_W'(ack_off) + CNT_W'(1);
                                    r_base_seq <= ack_seq_nx;
                                    r_state    <= S_PLAN;
                                end
                            end
                            ACT_TIMEOUT: begin
                                if (r_sending) begin
                                    r_rd_idx  <= r_base;
                                    r_rd_end  <= r_next;
                                    r_rd_seq  <= r_base_seq;
                                    r_rd_kind <= KIND_RESENT;
                                    r_state   <= S_BURST;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PLAN: begin
                    if (all_acked) begin
                        if (can_push) begin
                            r_sending <= 1'b0;
                            r_loaded  <= '0;
                            r_base    <= '0;
                            r_next    <= '0;
                            r_state   <= S_IDLE;
                        end
                    end else if (snd_end > r_next) begin
                        r_rd_idx  <= r_next;
                        r_rd_end  <= snd_end;
                        r_rd_seq  <= r_next_seq;
                        r_rd_kind <= KIND_SENT;
                        r_state   <= S_BURST;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_BURST: begin
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                        r_rd_seq <= rd_seq_inc;
                        if (r_rd_kind == KIND_SENT) begin
                            r_next     <= r_rd_idx + CNT_W'(1);
                            r_next_seq <= rd_seq_inc;
                        end
                        if (rd_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (!r_out_vld || pop) begin
                r_out_vld  <= r_skid_vld || r_pend_vld;
                r_skid_vld <= r_skid_vld && r_pend_vld;
            end else if (r_pend_vld) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // payload memory, read register and result queue data
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_payload_mem[r_loaded[IDX_W-1:0]] <= i_req.chunk_payload[DATA_W-1:0];
        end
        if (issue) begin
            r_rd_data <= r_payload_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (load_rej) begin
            r_pend_kind <= KIND_REJECT;
            r_pend_num  <= '0;
            r_pend_last <= 1'b1;
        end else if (plan_done) begin
            r_pend_kind <= KIND_DONE;
            r_pend_num  <= '0;
            r_pend_last <= 1'b1;
        end else if (issue) begin
            r_pend_kind <= r_rd_kind;
            r_pend_num  <= NUM_W'(r_rd_seq);
            r_pend_last <= rd_last;
        end else begin
            r_pend_kind <= r_pend_kind;
        end

        if (!r_out_vld || pop) begin
            r_out  <= r_skid_vld ? r_skid : pend_evt;
            r_skid <= pend_evt;
        end else if (r_pend_vld) begin
            r_skid <= pend_evt;
        end
    end

    assign o_evt.valid         = r_out_vld;
    assign o_evt.event_kind    = r_out.kind;
    assign o_evt.frame_number  = r_out.num;
    assign o_evt.frame_payload = r_out.payload;
    assign o_evt.run_end       = r_out.last;

    `GBN_ASSERT_IMPL(a_skid_behind_out, r_skid_vld, r_out_vld)
    `GBN_ASSERT_IMPL(a_no_overrun, r_pend_vld && r_out_vld && !pop, !r_skid_vld)
    `GBN_ASSERT_IMPL(a_window_order, 1'b1, (r_base <= r_next) && (r_next <= r_loaded))
    `GBN_ASSERT_IMPL(a_burst_bounds, r_state == S_BURST, r_rd_idx < r_rd_end)
    `GBN_ASSERT_NEXT(a_done_clears, plan_done, !r_sending && (r_loaded == '0))

endmodule

`default_nettype wire
